// File: rtl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;
        logic remove;
        logic clear;
        logic ordered;
    } t_cell_ctl;

endpackage

// File: rtl/spq_if.sv
// Request and result channel interfaces of the sorted priority queue.
interface spq_req_if #(
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            req_type;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface spq_res_if #(
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = $clog2(spq_pkg::DEPTH_DEF + 1)
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] removed_value;
    logic [1:0]            status;
    logic [COUNT_BITS-1:0] entry_count;
    logic                  is_empty;

    modport source (output valid, output removed_value, output status,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input removed_value, input status,
                    input entry_count, input is_empty, output ready);
endinterface

// File: rtl/sorted_priority_queue.sv
// Top level: bounded priority queue (FIFO or ascending order) built as a cell chain.
// Results come from a registered output, loaded when a request is accepted.
// Throughput: one request per cycle while the result side takes each result; insert and
//   remove each take one shift step of the cell chain, the insert point found by a ripple along the cells.
// Reset (synchronous, active low): count and ordered mode clear, no result pending;
//   cell values are left as they are, and their valid flags clear so the cells count as empty.
module sorted_priority_queue #(
    parameter int DEPTH      = spq_pkg::DEPTH_DEF,
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    spq_req_if.sink         i_req,
    spq_res_if.source       o_res
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // chain wiring
    logic [VALUE_BITS-1:0] w_value [DEPTH];
    logic                  w_valid [DEPTH];
    logic                  w_after [DEPTH];

    // control / status
    logic                  r_ordered;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  w_fire;
    logic                  w_full;
    logic                  w_empty;
    spq_pkg::t_cell_ctl    w_ctl;

    // result register, parts the request side from the result side
    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_removed;
    spq_pkg::t_status      r_status;
    logic [CNT_W-1:0]      r_out_count;
    logic                  r_out_empty;
    spq_pkg::t_status      n_status;
    logic [VALUE_BITS-1:0] n_removed;

    // A new request is taken whenever the result slot is free or drains now.
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_fire      = i_req.valid && i_req.ready;
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_empty     = (r_count == '0);

    // Rejected requests never reach the cells, so the store stays unchanged.
    always_comb begin
        w_ctl.insert  = w_fire && (i_req.req_type == spq_pkg::REQ_INSERT) && !w_full;
        w_ctl.remove  = w_fire && (i_req.req_type == spq_pkg::REQ_REMOVE) && !w_empty;
        w_ctl.clear   = w_fire && (i_req.req_type == spq_pkg::REQ_CLEAR);
        w_ctl.ordered = r_ordered;
    end

    // Status and count for this request; unused request code is a no-op.
    always_comb begin
        n_count   = r_count;
        n_status  = spq_pkg::ST_OK;
        n_removed = '0;
        case (i_req.req_type)
            spq_pkg::REQ_INSERT: begin
                if (w_full) begin
                    n_status = spq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            spq_pkg::REQ_REMOVE: begin
                if (w_empty) begin
                    n_status = spq_pkg::ST_EMPTY;
                end else begin
                    n_count   = r_count - CNT_W'(1);
                    n_removed = w_value[0];   // head of the chain
                end
            end
            spq_pkg::REQ_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    // Cell chain: each cell sees its left and right neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VALUE_BITS-1:0] w_lv;
        logic                  w_lvld;
        logic                  w_laft;
        logic [VALUE_BITS-1:0] w_rv;
        logic                  w_rvld;

        if (g == 0) begin : g_first
            assign w_lv   = '0;
            assign w_lvld = 1'b0;
            assign w_laft = 1'b0;
        end else begin : g_mid
            assign w_lv   = w_value[g-1];
            assign w_lvld = w_valid[g-1];
            assign w_laft = w_after[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_rv   = '0;
            assign w_rvld = 1'b0;
        end else begin : g_inner
            assign w_rv   = w_value[g+1];
            assign w_rvld = w_valid[g+1];
        end

        spq_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_new_value   (i_req.value),
            .i_left_value  (w_lv),
            .i_left_valid  (w_lvld),
            .i_left_after  (w_laft),
            .i_right_value (w_rv),
            .i_right_valid (w_rvld),
            .o_value       (w_value[g]),
            .o_valid       (w_valid[g]),
            .o_after       (w_after[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ordered   <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_ordered <= i_cfg_wdata;
            end
            if (w_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_fire) begin
            r_removed   <= n_removed;
            r_status    <= n_status;
            r_out_count <= n_count;
            r_out_empty <= (n_count == '0);
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.removed_value = r_removed;
    assign o_res.status        = r_status;
    assign o_res.entry_count   = r_out_count;
    assign o_res.is_empty      = r_out_empty;

endmodule

// File: rtl/spq_cell.sv
// One storage cell of the shift chain: holds a value and its valid flag.
module spq_cell #(
    parameter int VALUE_BITS = spq_pkg::VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  spq_pkg::t_cell_ctl    i_ctl,
    input  logic [VALUE_BITS-1:0] i_new_value,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic                  i_left_valid,
    input  logic                  i_left_after,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_right_valid,
    output logic [VALUE_BITS-1:0] o_value,
    output logic                  o_valid,
    output logic                  o_after
);

    logic [VALUE_BITS-1:0] r_value;
    logic                  r_valid;
    logic [VALUE_BITS-1:0] n_value;
    logic                  n_valid;
    logic                  w_pass;     // new value goes behind this cell
    logic                  w_here;     // insertion point is this cell

    // New value passes a stored one: FIFO passes every valid entry,
    // ordered mode only strictly smaller ones.
    assign w_pass  = r_valid && (!i_ctl.ordered ||
                                 ($signed(i_new_value) > $signed(r_value)));
    assign o_after = i_left_after || !w_pass;
    assign w_here  = o_after && !i_left_after;

    always_comb begin
        n_value = r_value;
        n_valid = r_valid;
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end else if (i_ctl.insert) begin
            if (i_left_after) begin
                n_value = i_left_value;
                n_valid = r_valid || i_left_valid;
            end else if (w_here) begin
                n_value = i_new_value;
                n_valid = 1'b1;
            end
        end else if (i_ctl.remove) begin
            n_value = i_right_value;
            n_valid = i_right_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_value <= n_value;
    end

    assign o_value = r_value;
    assign o_valid = r_valid;

endmodule
